// File: rtl/sdiv_pkg.sv
// Shared constants, types and helpers for the signed integer divider.
package sdiv_pkg;

    localparam int DATA_W = 32;
    localparam int QUOT_W = DATA_W + 1;
    localparam int CNT_W  = $clog2(DATA_W);

    typedef logic [DATA_W-1:0] mag_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    // Unsigned magnitude of a two's complement operand; the most negative
    // value maps to 2^(DATA_W-1), which still fits.
    function automatic mag_t magnitude(input logic [DATA_W-1:0] v);
        mag_t neg;
        neg = ~v + 1'b1;
        return v[DATA_W-1] ? neg : v;
    endfunction

endpackage

// File: rtl/sdiv_core.sv
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
module sdiv_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  sdiv_pkg::mag_t             num,
    input  sdiv_pkg::mag_t             den,
    output sdiv_pkg::core_stat_t       stat,
    output sdiv_pkg::mag_t             quot
);
    import sdiv_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    mag_t             rem_reg, rem_next;
    mag_t             dvd_reg, dvd_next;
    mag_t             den_reg, den_next;

    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] diff;
    logic              sub_ok;

    // Shift in the next dividend bit, trial-subtract the divisor.
    assign shifted = {rem_reg, dvd_reg[DATA_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign sub_ok  = ~diff[DATA_W+1];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W - 1);
            rem_next  = '0;
            dvd_next  = num;
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = sub_ok ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            // quotient bits enter where dividend bits leave
            dvd_next = {dvd_reg[DATA_W-2:0], sub_ok};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = dvd_reg;

endmodule

// File: rtl/signed_integer_divider_top.sv
// Signed 32-bit divider, truncating quotient, with divide-by-zero flag.
// A request is accepted in ST_IDLE, divided by the core in ST_DIV, and loaded to the output from ST_FIX.
// A new request is accepted only in ST_IDLE; the serial divide loop sets this (one bit per cycle).
// A new request is taken while the previous result still waits on the output.
// Reset: synchronous, active low; clears control and output valid only.
module signed_integer_divider_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sdiv_pkg::DATA_W-1:0]   s_dividend,
    input  logic [sdiv_pkg::DATA_W-1:0]   s_divisor,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sdiv_pkg::QUOT_W-1:0]   m_quotient,
    output logic                          m_divide_by_zero
);
    import sdiv_pkg::*;

    state_t      state_reg, state_next;
    logic        neg_reg, neg_next;
    logic        dz_reg, dz_next;
    logic        m_valid_reg, m_valid_next;
    logic [QUOT_W-1:0] m_quotient_reg, m_quotient_next;
    logic        m_dz_reg, m_dz_next;

    logic        core_start;
    logic        out_load;
    core_stat_t  stat;
    mag_t        core_q;
    logic [QUOT_W-1:0] q_pos;
    logic [QUOT_W-1:0] q_neg;

    sdiv_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (core_start),
        .num     (magnitude(s_dividend)),
        .den     (magnitude(s_divisor)),
        .stat    (stat),
        .quot    (core_q)
    );

    assign q_pos = {1'b0, core_q};
    assign q_neg = ~q_pos + 1'b1;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        core_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    core_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (stat.done) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        neg_next        = neg_reg;
        dz_next         = dz_reg;
        m_quotient_next = m_quotient_reg;
        m_dz_next       = m_dz_reg;
        if (core_start) begin
            neg_next = s_dividend[DATA_W-1] ^ s_divisor[DATA_W-1];
            dz_next  = (s_divisor == '0);
        end
        if (out_load) begin
            // zero divisor: core result is meaningless, report 0
            m_quotient_next = dz_reg ? '0 : (neg_reg ? q_neg : q_pos);
            m_dz_next       = dz_reg;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg        <= neg_next;
        dz_reg         <= dz_next;
        m_quotient_reg <= m_quotient_next;
        m_dz_reg       <= m_dz_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_quotient       = m_quotient_reg;
    assign m_divide_by_zero = m_dz_reg;

`ifndef SYNTH
    a_dz_zero_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> m_quotient == '0)
        else $error("divide-by-zero result carries nonzero quotient");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> state_reg == ST_DIV)
        else $error("core finished outside of divide state");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.busy |-> !s_ready)
        else $error("request accepted while core busy");

    a_valid_from_fix: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_FIX))
        else $error("result raised without passing the fix stage");
`endif

endmodule
